// ----- rtl/core/sorted_tag_value_table_macros.svh -----
// Assertion macros for the checker file.
`ifndef SORTED_TAG_VALUE_TABLE_MACROS_SVH
`define SORTED_TAG_VALUE_TABLE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define STVT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define STVT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/stvt_pkg.sv -----
`default_nettype none
package stvt_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  localparam logic [1:0] CmdAdd = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdGet = 2'd2;
  localparam logic [1:0] CmdList = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [31:0] tag;
    logic [31:0] new_value;
  } stvt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] out_tag;
    logic [31:0] out_value;
    logic last;
    logic [6:0] entry_count;
  } stvt_out_t;

  typedef enum logic [2:0] {
    StIdle, StSearch, StShiftUp, StShiftDown, StWrite, StList, StReply
  } stvt_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the command
    logic scan;      // read entry at scan index, advance
    logic shift_up;  // move entry idx-1 to idx, step down
    logic shift_down;// move entry idx to idx-1, step up
    logic write;     // write tag/value at pos
    logic write_val; // write value only at pos
    logic inc;
    logic dec;
    logic emit;
    logic emit_list;
  } stvt_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic scan_done;  // found position or reached count; set at once for list or empty table
    logic hit;
    logic full;
    logic empty;
    logic move_done;
    logic list_done;
  } stvt_sts_t;

  function automatic logic [31:0] order_key(input logic [31:0] t);
    return t ^ 32'h8080_8080;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/stvt_ram.sv -----
`default_nettype none
module stvt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/stvt_ctrl.sv -----
`default_nettype none
module stvt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire stvt_pkg::stvt_sts_t sts_i,
  output stvt_pkg::stvt_ctl_t     ctl_o,
  output logic                    busy_o
);
  import stvt_pkg::*;

  stvt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (sts_i.scan_done) begin
          case (sts_i.cmd)
            CmdAdd: begin
              if (sts_i.hit) begin
                state_d = StWrite;
              end else if (sts_i.full) begin
                state_d = StReply;
              end else begin
                state_d = StShiftUp;
              end
            end
            CmdRemove: state_d = sts_i.hit ? StShiftDown : StReply;
            CmdGet:    state_d = StReply;
            default:   state_d = sts_i.empty ? StReply : StList;
          endcase
        end
      end
      StShiftUp:   if (sts_i.move_done) state_d = StWrite;
      StShiftDown: if (sts_i.move_done) state_d = StReply;
      StWrite:     state_d = StReply;
      StList:      if (sts_i.list_done) state_d = StIdle;
      StReply:     state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    busy_o = (state_q != StIdle);
    case (state_q)
      StIdle:      ctl_o.load = start_i;
      StSearch:    ctl_o.scan = 1'b1;
      StShiftUp:   ctl_o.shift_up = 1'b1;
      StShiftDown: ctl_o.shift_down = 1'b1;
      StWrite: begin
        ctl_o.write = ~sts_i.hit;
        ctl_o.write_val = sts_i.hit;
        ctl_o.inc = ~sts_i.hit;
      end
      StList:      ctl_o.emit_list = 1'b1;
      StReply: begin
        ctl_o.emit = 1'b1;
        ctl_o.dec = (sts_i.cmd == CmdRemove) && sts_i.hit;
      end
      default:     ctl_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/stvt_dpath.sv -----
`default_nettype none
module stvt_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire stvt_pkg::stvt_in_t   in_i,
  input  wire stvt_pkg::stvt_ctl_t  ctl_i,
  output stvt_pkg::stvt_sts_t       sts_o,
  output logic                      valid_o,
  output stvt_pkg::stvt_out_t       out_o
);
  import stvt_pkg::*;

  stvt_in_t         cmd_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;     // scan / move / list cursor
  logic [CntW-1:0]  pos_q, pos_d;
  logic             hit_q, full_q;
  logic [31:0]      get_val_q;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_idx_q;         // address of data in rdata
  logic             mv_vld_q, mv_vld_d;
  logic [IdxW-1:0]  mv_dst_q, mv_dst_d;
  logic [IdxW-1:0]  raddr, waddr;
  logic [31:0]      tag_rd, val_rd, wtag, wval;
  logic             we_tag, we_val;
  logic             cmp_lt, tag_eq, rd_last;
  logic             scan_done, fhit;
  logic [CntW-1:0]  fpos;
  logic             valid_q, valid_d;
  stvt_out_t        out_q, out_d;

  stvt_ram #(.Width(32), .Depth(Capacity)) u_tag_ram (
    .clk_i, .we_i(we_tag), .waddr_i(waddr), .wdata_i(wtag),
    .raddr_i(raddr), .rdata_o(tag_rd)
  );
  stvt_ram #(.Width(32), .Depth(Capacity)) u_val_ram (
    .clk_i, .we_i(we_val), .waddr_i(waddr), .wdata_i(wval),
    .raddr_i(raddr), .rdata_o(val_rd)
  );

  // Read data arrives in the cycle after its address, tagged with rd_idx.
  assign cmp_lt  = order_key(tag_rd) < order_key(cmd_q.tag);
  assign tag_eq  = (tag_rd == cmd_q.tag);
  assign rd_last = (CntW'(rd_idx_q) + 1'b1) == count_q;

  // List needs no search; an empty table ends it at once.
  assign scan_done = (cmd_q.cmd == CmdList) || (count_q == '0)
                   || (rd_vld_q && (!cmp_lt || rd_last));
  assign fpos = !rd_vld_q ? '0 : (CntW'(rd_idx_q) + CntW'(cmp_lt));
  assign fhit = rd_vld_q && !cmp_lt && tag_eq;

  always_comb begin
    idx_d = idx_q;
    pos_d = pos_q;
    count_d = count_q;
    rd_vld_d = 1'b0;
    mv_vld_d = 1'b0;
    mv_dst_d = mv_dst_q;
    raddr = idx_q[IdxW-1:0];
    waddr = mv_dst_q;
    wtag = tag_rd;
    wval = val_rd;
    we_tag = 1'b0;
    we_val = 1'b0;
    if (ctl_i.load) begin
      idx_d = '0;
    end else if (ctl_i.scan) begin
      if (scan_done) begin
        pos_d = fpos;
        // start cursor for the move or list phase
        case (cmd_q.cmd)
          CmdAdd:    idx_d = count_q;
          CmdRemove: idx_d = fpos + 1'b1;
          default:   idx_d = '0;
        endcase
      end else begin
        rd_vld_d = (idx_q < count_q);
        idx_d = idx_q + 1'b1;
      end
    end else if (ctl_i.shift_up) begin
      raddr = idx_q[IdxW-1:0] - 1'b1;
      if (idx_q != pos_q) begin
        mv_vld_d = 1'b1;
        mv_dst_d = idx_q[IdxW-1:0];
        idx_d = idx_q - 1'b1;
      end
    end else if (ctl_i.shift_down) begin
      if (idx_q < count_q) begin
        mv_vld_d = 1'b1;
        mv_dst_d = idx_q[IdxW-1:0] - 1'b1;
        idx_d = idx_q + 1'b1;
      end
    end else if (ctl_i.emit_list) begin
      if (idx_q < count_q) begin
        rd_vld_d = 1'b1;
        idx_d = idx_q + 1'b1;
      end
    end
    // Write the entry read in the previous move cycle.
    if (mv_vld_q) begin
      we_tag = 1'b1;
      we_val = 1'b1;
    end
    if (ctl_i.write || ctl_i.write_val) begin
      waddr = pos_q[IdxW-1:0];
      wtag = cmd_q.tag;
      wval = cmd_q.new_value;
      we_tag = ctl_i.write;
      we_val = 1'b1;
    end
    if (ctl_i.inc) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_d = out_q;
    valid_d = 1'b0;
    if (ctl_i.emit) begin
      valid_d = 1'b1;
      out_d.status = StOk;
      out_d.out_tag = cmd_q.tag;
      out_d.out_value = '0;
      out_d.last = 1'b1;
      out_d.entry_count = 7'(count_d);
      case (cmd_q.cmd)
        CmdAdd:    out_d.status = full_q ? StFull : StOk;
        CmdRemove: out_d.status = hit_q ? StOk : StNotFound;
        CmdGet: begin
          out_d.status = hit_q ? StOk : StNotFound;
          out_d.out_value = hit_q ? get_val_q : '0;
        end
        default:   out_d.status = StEmpty;
      endcase
    end else if (ctl_i.emit_list && rd_vld_q) begin
      valid_d = 1'b1;
      out_d.status = StOk;
      out_d.out_tag = tag_rd;
      out_d.out_value = val_rd;
      out_d.last = rd_last;
      out_d.entry_count = 7'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
      count_q <= '0;
      idx_q <= '0;
      pos_q <= '0;
      hit_q <= 1'b0;
      full_q <= 1'b0;
      get_val_q <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      mv_vld_q <= 1'b0;
      mv_dst_q <= '0;
      valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      if (ctl_i.load) begin
        cmd_q <= in_i;
      end
      count_q <= count_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
      rd_vld_q <= rd_vld_d;
      rd_idx_q <= raddr;
      mv_vld_q <= mv_vld_d;
      mv_dst_q <= mv_dst_d;
      if (ctl_i.scan && scan_done) begin
        hit_q <= fhit;
        full_q <= !fhit && (count_q == CntW'(Capacity));
        get_val_q <= val_rd;
      end
      valid_q <= valid_d;
      out_q <= out_d;
    end
  end

  assign sts_o.cmd = cmd_q.cmd;
  assign sts_o.scan_done = scan_done;
  assign sts_o.hit = ctl_i.scan ? fhit : hit_q;
  assign sts_o.full = (count_q == CntW'(Capacity));
  assign sts_o.empty = (count_q == '0);
  assign sts_o.move_done = ctl_i.shift_up ? (idx_q == pos_q) : (idx_q >= count_q);
  assign sts_o.list_done = rd_vld_q && rd_last;

  assign valid_o = valid_q;
  assign out_o = out_q;
endmodule
`default_nettype wire

// ----- rtl/core/sorted_tag_value_table.sv -----
// Channel  | Signals                  | Handshake
// command  | start_i, in_i            | transfer when start_i && !busy_o
// result   | done_o, out_o            | done_o marks each result, no stall
// n entries, p the first position not below the tag. The search reads one entry a
// cycle and stops at p or at entry n-1; it ends at once on an empty table or list.
// A new add shifts one entry a cycle, then writes; list emits one result a cycle.
// Each result strobes the cycle after it forms; the last lands as busy_o drops.
// Reset clears the entry count; the stores are undefined until written.
`default_nettype none
module sorted_tag_value_table (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire stvt_pkg::stvt_in_t in_i,
  output logic                    busy_o,
  output logic                    done_o,
  output stvt_pkg::stvt_out_t     out_o
);
  import stvt_pkg::*;

  stvt_ctl_t ctl;
  stvt_sts_t sts;
  logic      ctrl_busy;

  stvt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .sts_i(sts), .ctl_o(ctl), .busy_o(ctrl_busy)
  );
  stvt_dpath u_dpath (
    .clk_i, .rst_ni, .in_i, .ctl_i(ctl), .sts_o(sts), .valid_o(done_o), .out_o
  );

  assign busy_o = ctrl_busy;
endmodule
`default_nettype wire

// ----- rtl/core/stvt_checker.sv -----
`default_nettype none
`include "sorted_tag_value_table_macros.svh"
module stvt_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_i,
  input wire logic               done_i,
  input wire stvt_pkg::stvt_out_t out_i
);
  import stvt_pkg::*;
  `STVT_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_i && !busy_i, busy_i)
  `STVT_ASSERT_IMP(a_count_range, clk_i, rst_ni, done_i, out_i.entry_count <= 7'(Capacity))
  `STVT_ASSERT_IMP(a_full_count, clk_i, rst_ni, done_i && out_i.status == StFull,
    out_i.entry_count == 7'(Capacity) && out_i.last)
  `STVT_ASSERT_IMP(a_empty_last, clk_i, rst_ni, done_i && out_i.status == StEmpty,
    out_i.last && out_i.entry_count == 7'd0)
endmodule

bind sorted_tag_value_table stvt_checker u_stvt_checker (
  .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .done_i(done_o), .out_i(out_o)
);
`default_nettype wire
